@@ src/maad_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the multichannel audio activity detector.
// No dependencies; every other file in src imports this package.
package maad_pkg;

   localparam int MAX_CHANNELS = 8;
   localparam int LEVEL_W      = 10;
   localparam int MASK_W       = 8;
   localparam int THR_W        = 10;
   localparam int HOLD_W       = 16;
   localparam int CSR_DATA_W   = 32;
   localparam int CSR_ADDR_W   = 3;

   localparam logic [LEVEL_W-1:0] START_LEVEL     = 10'd550;
   localparam logic [THR_W-1:0]   RESET_THRESHOLD = 10'd10;
   localparam logic [HOLD_W-1:0]  RESET_HOLD      = 16'd100;

   typedef enum logic [0:0] {
      CSR_THRESHOLD = 1'b0,
      CSR_HOLD      = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_TAIL,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] base;
      logic [HOLD_W-1:0]  hold;
   } chan_entry_type;

endpackage

@@ src/maad_if.sv @@
`timescale 1ns / 1ps
// Valid/ready channel interfaces for sample sets and activity results.
// Depends on maad_pkg for the field widths.
interface maad_req_if import maad_pkg::*; ;
   logic               valid;
   logic               ready;
   logic [LEVEL_W-1:0] level_0;
   logic [LEVEL_W-1:0] level_1;
   logic [LEVEL_W-1:0] level_2;
   logic [LEVEL_W-1:0] level_3;
   logic [LEVEL_W-1:0] level_4;
   logic [LEVEL_W-1:0] level_5;
   logic [LEVEL_W-1:0] level_6;
   logic [LEVEL_W-1:0] level_7;

   modport source (output valid, level_0, level_1, level_2, level_3,
                   level_4, level_5, level_6, level_7, input ready);
   modport sink (input valid, level_0, level_1, level_2, level_3,
                 level_4, level_5, level_6, level_7, output ready);
endinterface

interface maad_rsp_if import maad_pkg::*; ;
   logic              valid;
   logic              ready;
   logic [MASK_W-1:0] activity_mask;
   logic              mask_changed;

   modport source (output valid, activity_mask, mask_changed, input ready);
   modport sink (input valid, activity_mask, mask_changed, output ready);
endinterface

@@ src/multichannel_audio_activity_detector_unit.sv @@
`timescale 1ns / 1ps
// Multichannel audio activity detector: one sample set in, one activity mask out.
// Each transaction writes one sample per channel into a window memory of
// CHANNELS x WINDOW_DEPTH entries while it scans that memory through its single
// read port, one entry per cycle, to find each channel's window peak. Baseline
// and hold counter of each channel sit in a second small memory that is read at
// the start of the channel's scan and written back at its end. After the scan
// the unit passes a tail state, then a finish state that loads the result into
// the output register once that register is free, and then returns to idle; it
// takes no new transaction until then. A new transaction is accepted while the
// previous result still waits in the output register.
// The window memory is not cleared: a fill count marks unwritten positions,
// which read as the start level 550.
module multichannel_audio_activity_detector_unit import maad_pkg::*; #(
   parameter int CHANNELS     = 8,
   parameter int WINDOW_DEPTH = 30,
   parameter int SAMPLE_BITS  = 10
) (
   input  logic                  clock,
   input  logic                  reset,
   maad_req_if.sink              req_bus,
   maad_rsp_if.source            rsp_bus,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int CH_BITS    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int S_BITS     = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
   localparam int FILL_BITS  = $clog2(WINDOW_DEPTH + 1);
   localparam int ENTRIES    = CHANNELS * WINDOW_DEPTH;
   localparam int ADDR_BITS  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int STORE_BITS = (SAMPLE_BITS < LEVEL_W) ? SAMPLE_BITS : LEVEL_W;
   localparam int CMP_BITS   = (S_BITS > FILL_BITS) ? S_BITS : FILL_BITS;

   localparam logic [CH_BITS-1:0]   LAST_CH = CH_BITS'(CHANNELS - 1);
   localparam logic [S_BITS-1:0]    LAST_S  = S_BITS'(WINDOW_DEPTH - 1);
   localparam logic [FILL_BITS-1:0] FULL    = FILL_BITS'(WINDOW_DEPTH);

   // configuration
   logic [THR_W-1:0]  threshold_ff;
   logic [HOLD_W-1:0] hold_ticks_ff;
   logic              csr_write;

   // control
   state_type state_ff, state_in;
   logic      req_ready;
   logic      issue;
   logic      load_rsp;
   logic      out_free;
   logic      last_issue;

   // sequencing
   logic [CH_BITS-1:0]   ch_ff;
   logic [S_BITS-1:0]    s_ff;
   logic [ADDR_BITS-1:0] addr_ff;
   logic [S_BITS-1:0]    slot_ff;
   logic [FILL_BITS-1:0] fill_ff;
   logic [MASK_W-1:0]    mask_ff;
   logic [MASK_W-1:0]    mask_in;
   logic [MASK_W-1:0]    prev_mask_ff;

   // sample latch and memories
   logic [LEVEL_W-1:0]    level_in [MAX_CHANNELS];
   logic [STORE_BITS-1:0] levels_ff [CHANNELS];
   logic [STORE_BITS-1:0] win_mem [ENTRIES];
   logic [STORE_BITS-1:0] win_rd_ff;
   chan_entry_type        chan_mem [CHANNELS];
   chan_entry_type        chan_rd_ff;
   logic                  chan_rd_vld_ff;
   logic [CHANNELS-1:0]   chan_vld_ff;

   // data stage
   logic                  d_valid_ff;
   logic                  d_first_ff;
   logic                  d_last_ff;
   logic                  d_sub_ff;
   logic                  d_written_ff;
   logic [CH_BITS-1:0]    d_ch_ff;
   logic [STORE_BITS-1:0] d_sample_ff;
   logic [LEVEL_W-1:0]    peak_ff;
   logic [LEVEL_W-1:0]    value;
   logic [LEVEL_W-1:0]    running;
   logic                  proc;
   logic [LEVEL_W-1:0]    base_old;
   logic [HOLD_W-1:0]     hold_old;
   logic [LEVEL_W-1:0]    base_new;
   logic [LEVEL_W-1:0]    diff;
   logic                  over;
   logic [HOLD_W-1:0]     hold_new;
   logic                  active;
   logic [CH_BITS-1:0]    bit_pos;

   // result register
   logic              rsp_valid_ff;
   logic [MASK_W-1:0] rsp_mask_ff;
   logic              rsp_changed_ff;

   // ---------------------------------------------------------------- csr
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff  <= RESET_THRESHOLD;
         hold_ticks_ff <= RESET_HOLD;
      end else if (csr_write) begin
         unique case (csr_index_type'(csr_paddr[2]))
            CSR_THRESHOLD: threshold_ff  <= csr_pwdata[THR_W-1:0];
            CSR_HOLD:      hold_ticks_ff <= csr_pwdata[HOLD_W-1:0];
            default:       ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index_type'(csr_paddr[2]))
         CSR_THRESHOLD: csr_prdata = CSR_DATA_W'(threshold_ff);
         CSR_HOLD:      csr_prdata = CSR_DATA_W'(hold_ticks_ff);
         default:       csr_prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------- fsm
   assign out_free   = !rsp_valid_ff || rsp_bus.ready;
   assign last_issue = (ch_ff == LAST_CH) && (s_ff == LAST_S);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (req_bus.valid) state_in = ST_SCAN;
         ST_SCAN:   if (last_issue) state_in = ST_TAIL;
         ST_TAIL:   state_in = ST_FINISH;
         ST_FINISH: if (out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      issue     = 1'b0;
      load_rsp  = 1'b0;
      unique case (state_ff)
         ST_IDLE:   req_ready = 1'b1;
         ST_SCAN:   issue = 1'b1;
         ST_TAIL:   ;
         ST_FINISH: load_rsp = out_free;
         default:   ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_bus.ready = req_ready;

   // ---------------------------------------------------------------- sequencing
   assign level_in[0] = req_bus.level_0;
   assign level_in[1] = req_bus.level_1;
   assign level_in[2] = req_bus.level_2;
   assign level_in[3] = req_bus.level_3;
   assign level_in[4] = req_bus.level_4;
   assign level_in[5] = req_bus.level_5;
   assign level_in[6] = req_bus.level_6;
   assign level_in[7] = req_bus.level_7;

   always_ff @(posedge clock) begin
      if (req_ready && req_bus.valid) begin
         for (int i = 0; i < CHANNELS; i++) begin
            levels_ff[i] <= level_in[i][STORE_BITS-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ch_ff   <= '0;
         s_ff    <= '0;
         addr_ff <= '0;
         slot_ff <= '0;
         fill_ff <= '0;
         mask_ff <= '0;
         prev_mask_ff <= '0;
      end else begin
         if (req_ready && req_bus.valid) begin
            ch_ff   <= '0;
            s_ff    <= '0;
            addr_ff <= '0;
            mask_ff <= '0;
         end else begin
            if (issue) begin
               addr_ff <= addr_ff + 1'b1;
               if (s_ff == LAST_S) begin
                  s_ff  <= '0;
                  ch_ff <= ch_ff + 1'b1;
               end else begin
                  s_ff <= s_ff + 1'b1;
               end
            end
            mask_ff <= mask_in;
         end
         if (load_rsp) begin
            prev_mask_ff <= mask_ff;
            slot_ff <= (slot_ff == LAST_S) ? '0 : slot_ff + 1'b1;
            if (fill_ff != FULL) begin
               fill_ff <= fill_ff + 1'b1;
            end
         end
      end
   end

   // ---------------------------------------------------------------- memories
   always_ff @(posedge clock) begin
      if (issue) begin
         win_rd_ff <= win_mem[addr_ff];
         if (s_ff == slot_ff) begin
            win_mem[addr_ff] <= levels_ff[ch_ff];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (issue && s_ff == '0) begin
         chan_rd_ff <= chan_mem[ch_ff];
      end
      if (proc) begin
         chan_mem[d_ch_ff] <= '{base: base_new, hold: hold_new};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chan_vld_ff    <= '0;
         chan_rd_vld_ff <= 1'b0;
      end else begin
         if (issue && s_ff == '0) begin
            chan_rd_vld_ff <= chan_vld_ff[ch_ff];
         end
         if (proc) begin
            chan_vld_ff[d_ch_ff] <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------- data stage
   always_ff @(posedge clock) begin
      if (reset) begin
         d_valid_ff <= 1'b0;
      end else begin
         d_valid_ff <= issue;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         d_first_ff   <= (s_ff == '0);
         d_last_ff    <= (s_ff == LAST_S);
         d_sub_ff     <= (s_ff == slot_ff);
         d_written_ff <= (CMP_BITS'(s_ff) < CMP_BITS'(fill_ff));
         d_ch_ff      <= ch_ff;
         d_sample_ff  <= levels_ff[ch_ff];
      end
      if (d_valid_ff) begin
         peak_ff <= running;
      end
   end

   always_comb begin
      if (d_sub_ff) begin
         value = LEVEL_W'(d_sample_ff);
      end else if (d_written_ff) begin
         value = LEVEL_W'(win_rd_ff);
      end else begin
         value = START_LEVEL;
      end
      running = (d_first_ff || value > peak_ff) ? value : peak_ff;
   end

   assign proc = d_valid_ff && d_last_ff;

   always_comb begin
      base_old = chan_rd_vld_ff ? chan_rd_ff.base : START_LEVEL;
      hold_old = chan_rd_vld_ff ? chan_rd_ff.hold : '0;
      base_new = (running < base_old) ? running : base_old;
      diff     = running - base_new;
      over     = (diff > LEVEL_W'(threshold_ff));
      if (over) begin
         hold_new = hold_ticks_ff;
      end else if (hold_old != '0) begin
         hold_new = hold_old - 1'b1;
      end else begin
         hold_new = hold_old;
      end
      active  = over || (hold_old != '0);
      bit_pos = LAST_CH - d_ch_ff;
      mask_in = mask_ff;
      if (proc && active) begin
         mask_in = mask_ff | (MASK_W'(1) << bit_pos);
      end
   end

   // ---------------------------------------------------------------- result
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_mask_ff    <= mask_ff;
         rsp_changed_ff <= (mask_ff != prev_mask_ff);
      end
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.activity_mask = rsp_mask_ff;
   assign rsp_bus.mask_changed  = rsp_changed_ff;

endmodule

@@ src/maad_checker.sv @@
`timescale 1ns / 1ps
// Port-level assertions for the activity detector, bound to its top level.
// Depends on maad_pkg and on the top level's channel interfaces.
module maad_checker import maad_pkg::*; #(
   parameter int CHANNELS = 8
) (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [MASK_W-1:0] activity_mask,
   input logic              mask_changed
);

   logic [1:0]        pending_ff;
   logic [MASK_W-1:0] last_mask_ff;
   logic              req_acc;
   logic              rsp_acc;

   assign req_acc = req_valid && req_ready;
   assign rsp_acc = rsp_valid && rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff   <= '0;
         last_mask_ff <= '0;
      end else begin
         pending_ff <= pending_ff + {1'b0, req_acc} - {1'b0, rsp_acc};
         if (rsp_acc) begin
            last_mask_ff <= activity_mask;
         end
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(activity_mask)
         && $stable(mask_changed))
      else $error("result dropped or changed while stalled");

   a_no_orphan: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != 2'd0)
      else $error("result without an accepted sample set");

   a_depth: assert property (@(posedge clock) disable iff (reset)
      pending_ff != 2'd3)
      else $error("more than two sample sets in flight");

   a_changed: assert property (@(posedge clock) disable iff (reset)
      rsp_acc |-> mask_changed == (activity_mask != last_mask_ff))
      else $error("change flag disagrees with previous mask");

   a_unused_bits: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (activity_mask >> CHANNELS) == '0)
      else $error("mask bit set for a channel that does not exist");

endmodule

bind multichannel_audio_activity_detector_unit maad_checker #(
   .CHANNELS(CHANNELS)
) u_maad_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_bus.valid),
   .req_ready     (req_bus.ready),
   .rsp_valid     (rsp_bus.valid),
   .rsp_ready     (rsp_bus.ready),
   .activity_mask (rsp_bus.activity_mask),
   .mask_changed  (rsp_bus.mask_changed)
);

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking bench for the multichannel audio activity detector unit.
// Predicts each activity mask from its own window, baseline and hold model.
// Depends on maad_pkg, the maad_req_if/maad_rsp_if interfaces and the unit.
module tb_top;
   import maad_pkg::*;

   localparam int CHANNELS     = MAX_CHANNELS;
   localparam int WINDOW_DEPTH = 30;
   localparam int SESSIONS     = 11;
   localparam int SESSION_LEN  = 100;
   localparam int DRAIN_CYCLES = 300;
   localparam int CYCLE_LIMIT  = 1_200_000;
   localparam int LEVEL_MAX    = (1 << LEVEL_W) - 1;
   localparam int THR_MAX      = (1 << THR_W) - 1;
   localparam int HOLD_MAX     = (1 << HOLD_W) - 1;

   typedef logic [LEVEL_W-1:0] level_type;
   typedef logic [CHANNELS-1:0][LEVEL_W-1:0] level_set_type;

   typedef struct packed {
      logic [MASK_W-1:0] activity_mask;
      logic              mask_changed;
   } activity_type;

   logic clock;
   logic reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   maad_req_if req_bus ();
   maad_rsp_if rsp_bus ();

   multichannel_audio_activity_detector_unit i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // detector model state
   level_type         window_mem [CHANNELS][WINDOW_DEPTH];
   int                next_slot;
   level_type         floor_level [CHANNELS];
   logic [HOLD_W-1:0] hold_left [CHANNELS];
   logic [MASK_W-1:0] last_mask;
   logic [THR_W-1:0]  threshold_reg;
   logic [HOLD_W-1:0] hold_reg;

   activity_type pending_masks [$];
   int           failures;
   int           cycle_count;
   int           stall_left;
   bit           idling;

   // per-channel loud/quiet pattern for the random sessions
   bit     loud [CHANNELS];
   int     run_left [CHANNELS];
   int     quiet_floor [CHANNELS];

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_top NOT OK");
         $finish;
      end
   end

   function automatic void clear_detector_model();
      for (int k = 0; k < CHANNELS; k++) begin
         for (int s = 0; s < WINDOW_DEPTH; s++) begin
            window_mem[k][s] = START_LEVEL;
         end
         floor_level[k] = START_LEVEL;
         hold_left[k]   = '0;
      end
      next_slot     = 0;
      last_mask     = '0;
      threshold_reg = RESET_THRESHOLD;
      hold_reg      = RESET_HOLD;
   endfunction

   function automatic activity_type predict_activity(input level_set_type levels);
      activity_type      result;
      level_type         peak;
      logic [MASK_W-1:0] mask;
      mask = '0;
      for (int k = 0; k < CHANNELS; k++) begin
         window_mem[k][next_slot] = levels[k];
      end
      next_slot = (next_slot + 1) % WINDOW_DEPTH;
      for (int k = 0; k < CHANNELS; k++) begin
         peak = '0;
         for (int s = 0; s < WINDOW_DEPTH; s++) begin
            if (window_mem[k][s] > peak) peak = window_mem[k][s];
         end
         if (peak < floor_level[k]) floor_level[k] = peak;
         if (int'(peak) - int'(floor_level[k]) > int'(threshold_reg)) begin
            hold_left[k] = hold_reg;
            mask[CHANNELS-1-k] = 1'b1;
         end else if (hold_left[k] != '0) begin
            hold_left[k] = hold_left[k] - 1'b1;
            mask[CHANNELS-1-k] = 1'b1;
         end
      end
      result.activity_mask = mask;
      result.mask_changed  = (mask != last_mask);
      last_mask = mask;
      return result;
   endfunction

   // result side: random stalls, compare each transaction with the oldest prediction
   always @(posedge clock) begin
      activity_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         stall_left    <= 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (pending_masks.size() == 0) begin
               $error("unexpected result: activity_mask %02h mask_changed %0b",
                      rsp_bus.activity_mask, rsp_bus.mask_changed);
               failures++;
            end else begin
               want = pending_masks.pop_front();
               if (rsp_bus.activity_mask !== want.activity_mask) begin
                  $error("activity_mask: expected %02h, got %02h",
                         want.activity_mask, rsp_bus.activity_mask);
                  failures++;
               end
               if (rsp_bus.mask_changed !== want.mask_changed) begin
                  $error("mask_changed: expected %0b, got %0b",
                         want.mask_changed, rsp_bus.mask_changed);
                  failures++;
               end
            end
         end
         if (stall_left != 0) begin
            rsp_bus.ready <= 1'b0;
            stall_left    <= stall_left - 1;
         end else if (idling && $urandom_range(0, 7) == 0) begin
            rsp_bus.ready <= 1'b0;
            stall_left    <= $urandom_range(0, 4);
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   task automatic send_levels(input level_set_type levels);
      int gap;
      if (idling && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 5);
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.level_0 <= levels[0];
      req_bus.level_1 <= levels[1];
      req_bus.level_2 <= levels[2];
      req_bus.level_3 <= levels[3];
      req_bus.level_4 <= levels[4];
      req_bus.level_5 <= levels[5];
      req_bus.level_6 <= levels[6];
      req_bus.level_7 <= levels[7];
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      pending_masks.push_back(predict_activity(levels));
   endtask

   task automatic wait_masks_drained();
      req_bus.valid <= 1'b0;
      while (pending_masks.size() != 0) @(posedge clock);
   endtask

   // back-to-back accesses go straight from access to the next setup
   task automatic csr_access(input csr_index_type idx, input logic write,
                             input logic [CSR_DATA_W-1:0] wdata);
      logic [CSR_DATA_W-1:0] want;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (write) begin
         case (idx)
            CSR_THRESHOLD: threshold_reg = wdata[THR_W-1:0];
            CSR_HOLD:      hold_reg      = wdata[HOLD_W-1:0];
         endcase
      end else begin
         want = (idx == CSR_THRESHOLD) ? CSR_DATA_W'(threshold_reg) : CSR_DATA_W'(hold_reg);
         if (csr_prdata !== want) begin
            $error("csr_prdata %s: expected %0d, got %0d", idx.name(), want, csr_prdata);
            failures++;
         end
      end
   endtask

   task automatic csr_release();
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // random upper bits check that the unit masks each register to its width
   task automatic load_settings(input int thr, input int hold);
      wait_masks_drained();
      csr_access(CSR_THRESHOLD, 1'b1, ($urandom & ~32'h3FF) | CSR_DATA_W'(thr));
      csr_access(CSR_HOLD, 1'b1, ($urandom & ~32'hFFFF) | CSR_DATA_W'(hold));
      csr_access(CSR_THRESHOLD, 1'b0, '0);
      csr_access(CSR_HOLD, 1'b0, '0);
      csr_release();
   endtask

   function automatic level_set_type make_levels();
      level_set_type levels;
      int            lvl;
      if ($urandom_range(0, 19) == 0) begin
         for (int k = 0; k < CHANNELS; k++) begin
            levels[k] = level_type'($urandom_range(0, LEVEL_MAX));
         end
         return levels;
      end
      for (int k = 0; k < CHANNELS; k++) begin
         if (run_left[k] == 0) begin
            loud[k]     = !loud[k];
            run_left[k] = loud[k] ? $urandom_range(1, 12) : $urandom_range(10, 70);
         end
         run_left[k]--;
         if (loud[k]) begin
            lvl = $urandom_range(quiet_floor[k] + 1, LEVEL_MAX);
         end else begin
            lvl = quiet_floor[k] + $urandom_range(0, 6);
         end
         levels[k] = (lvl > LEVEL_MAX) ? level_type'(LEVEL_MAX) : level_type'(lvl);
      end
      return levels;
   endfunction

   task automatic test_register_access();
      csr_access(CSR_THRESHOLD, 1'b0, '0);
      csr_access(CSR_HOLD, 1'b0, '0);
      csr_access(CSR_THRESHOLD, 1'b1, '1);
      csr_access(CSR_HOLD, 1'b1, '1);
      csr_access(CSR_THRESHOLD, 1'b0, '0);
      csr_access(CSR_HOLD, 1'b0, '0);
      csr_release();
   endtask

   task automatic test_field_extremes();
      load_settings(0, 0);
      send_levels({CHANNELS{START_LEVEL}});
      send_levels('0);
      send_levels({CHANNELS{10'h155}});
      send_levels({CHANNELS{10'h2AA}});
      send_levels('1);
      load_settings(THR_MAX, HOLD_MAX);
      send_levels('1);
      send_levels('0);
      send_levels({CHANNELS{10'h2AA}});
   endtask

   task automatic test_slot_order();
      level_set_type levels;
      load_settings(RESET_THRESHOLD, RESET_HOLD);
      for (int k = 0; k < CHANNELS; k++) begin
         levels    = '0;
         levels[k] = level_type'(LEVEL_MAX);
         send_levels(levels);
      end
   endtask

   task automatic test_random_sessions();
      int thr;
      int hold;
      for (int session = 0; session < SESSIONS; session++) begin
         if (session == 0) begin
            thr  = 0;
            hold = 0;
         end else if (session == 1) begin
            thr  = THR_MAX;
            hold = $urandom_range(0, 20);
         end else if (session == SESSIONS - 1) begin
            thr  = $urandom_range(0, 100);
            hold = HOLD_MAX;
         end else if (session == 2) begin
            thr  = $urandom_range(0, THR_MAX);
            hold = $urandom_range(0, 8);
         end else begin
            thr  = $urandom_range(0, 60);
            hold = $urandom_range(0, 30);
         end
         load_settings(thr, hold);
         idling = (session != SESSIONS - 1) && ($urandom_range(0, 3) != 0);
         for (int k = 0; k < CHANNELS; k++) begin
            quiet_floor[k] = $urandom_range(0, 700);
            run_left[k]    = $urandom_range(0, 40);
         end
         repeat (SESSION_LEN) send_levels(make_levels());
      end
   endtask

   initial begin
      reset         <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.level_0 <= '0;
      req_bus.level_1 <= '0;
      req_bus.level_2 <= '0;
      req_bus.level_3 <= '0;
      req_bus.level_4 <= '0;
      req_bus.level_5 <= '0;
      req_bus.level_6 <= '0;
      req_bus.level_7 <= '0;
      csr_psel      <= 1'b0;
      csr_penable   <= 1'b0;
      csr_pwrite    <= 1'b0;
      csr_paddr     <= '0;
      csr_pwdata    <= '0;
      failures    = 0;
      cycle_count = 0;
      idling      = 1'b1;
      for (int k = 0; k < CHANNELS; k++) begin
         loud[k]        = 1'b0;
         run_left[k]    = 0;
         quiet_floor[k] = 0;
      end
      clear_detector_model();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_register_access();
      test_field_extremes();
      test_slot_order();
      test_random_sessions();

      wait_masks_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
src/maad_pkg.sv
src/maad_if.sv
src/multichannel_audio_activity_detector_unit.sv
src/maad_checker.sv
tb/sv/tb_top.sv
